// ----- sv/dmm_pkg.sv -----
// Shared constants, types and helpers for the dense matrix multiply core.
package dmm_pkg;

   // Matrix geometry and number formats
   localparam int MAX_DIM    = 8;
   localparam int ELEM_BITS  = 16;
   localparam int SUM_BITS   = 35;
   localparam int PROD_BITS  = 2 * ELEM_BITS;
   localparam int CELLS      = MAX_DIM * MAX_DIM;
   localparam int ADDR_BITS  = $clog2(CELLS);
   localparam int IDX_BITS   = $clog2(MAX_DIM);

   // Port field widths
   localparam int CMD_BITS   = 2;
   localparam int ROW_BITS   = 3;
   localparam int VALUE_BITS = 16;
   localparam int SIZE_BITS  = 4;
   localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(8);

   // Result status codes
   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_WRITE_A  = 2'd0,
      CMD_WRITE_B  = 2'd1,
      CMD_MULTIPLY = 2'd2,
      CMD_READ_C   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_MAC_RUN,
      ST_MAC_DRAIN
   } state_type;

   // One multiply-accumulate step handed from the sequencer to the MAC
   typedef struct packed {
      logic                 valid;
      logic                 first;
      logic                 last;
      logic [ADDR_BITS-1:0] c_addr;
   } issue_type;

   // Write of one finished sum into the product memory
   typedef struct packed {
      logic                       en;
      logic [ADDR_BITS-1:0]       addr;
      logic signed [SUM_BITS-1:0] data;
   } cwrite_type;

   // Column-major address of element (row, col)
   function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [ADDR_BITS-1:0] row,
                                                      input logic [ADDR_BITS-1:0] col);
      cell_addr = ADDR_BITS'(col * MAX_DIM + row);
   endfunction

endpackage

// ----- sv/dmm_req_if.sv -----
// Request channel: command, indices and element value.
interface dmm_req_if import dmm_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [CMD_BITS-1:0]          cmd;
   logic [ROW_BITS-1:0]          row;
   logic [ROW_BITS-1:0]          col;
   logic signed [VALUE_BITS-1:0] value;

   modport source (output valid, cmd, row, col, value, input ready);
   modport sink   (input valid, cmd, row, col, value, output ready);
endinterface

// ----- sv/dmm_rsp_if.sv -----
// Response channel: read value and status.
interface dmm_rsp_if import dmm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SUM_BITS-1:0] read_value;
   logic                       status;

   modport source (output valid, read_value, status, input ready);
   modport sink   (input valid, read_value, status, output ready);
endinterface

// ----- sv/dmm_elem_ram.sv -----
// Element RAM for one operand matrix: one write port, one registered read port.
module dmm_elem_ram import dmm_pkg::*; (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_BITS-1:0]        wr_addr,
   input  logic signed [ELEM_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0]        rd_addr,
   output logic signed [ELEM_BITS-1:0] rd_data
);

   logic signed [ELEM_BITS-1:0] mem [CELLS];
   logic signed [ELEM_BITS-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/dmm_product_mem.sv -----
// Product memory with per-entry valid bits; an entry not written since the last clear reads zero.
module dmm_product_mem import dmm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  cwrite_type                 wr,
   input  logic [ADDR_BITS-1:0]       rd_addr,
   output logic signed [SUM_BITS-1:0] rd_data
);

   logic signed [SUM_BITS-1:0] mem [CELLS];
   logic [CELLS-1:0]           valid_ff;
   logic [CELLS-1:0]           valid_in;
   logic signed [SUM_BITS-1:0] rd_data_ff;
   logic                       rd_hit_ff;

   // Drop all entries on clear, mark an entry on write
   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Storage write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Registered read with its valid bit
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      rd_hit_ff  <= valid_ff[rd_addr];
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : '0;

endmodule

// ----- sv/dmm_mac.sv -----
// Shared multiply-accumulate pipeline: operand fetch, multiply, accumulate, write back.
module dmm_mac import dmm_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  issue_type                   issue,
   input  logic signed [ELEM_BITS-1:0] a_data,
   input  logic signed [ELEM_BITS-1:0] b_data,
   output cwrite_type                  c_wr,
   output logic                        busy
);

   issue_type                   s1_ff;
   issue_type                   s2_ff;
   issue_type                   s3_ff;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [PROD_BITS-1:0] prod_in;
   logic signed [SUM_BITS-1:0]  acc_ff;
   logic signed [SUM_BITS-1:0]  acc_in;

   // Advance the step tags alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
      end else begin
         s1_ff <= issue;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
      end
   end

   // Multiply the operands that the RAMs return
   assign prod_in = PROD_BITS'(a_data * b_data);

   // Accumulate; the first step of a sum starts from zero, wraps modulo the sum width
   always_comb begin
      acc_in = acc_ff;
      if (s2_ff.valid) begin
         acc_in = (s2_ff.first ? '0 : acc_ff) + SUM_BITS'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // Write back a finished sum
   assign c_wr.en   = s3_ff.valid && s3_ff.last;
   assign c_wr.addr = s3_ff.c_addr;
   assign c_wr.data = acc_ff;

   assign busy = s1_ff.valid || s2_ff.valid || s3_ff.valid;

endmodule

// ----- sv/dmm_ctrl.sv -----
// Command decode, multiply sequencer and response register.
module dmm_ctrl import dmm_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   dmm_req_if.sink                     req_chan,
   dmm_rsp_if.source                   rsp_chan,
   input  logic [SIZE_BITS-1:0]        eff_size,
   output logic                        a_wr_en,
   output logic                        b_wr_en,
   output logic [ADDR_BITS-1:0]        elem_wr_addr,
   output logic signed [ELEM_BITS-1:0] elem_wr_data,
   output logic [ADDR_BITS-1:0]        a_rd_addr,
   output logic [ADDR_BITS-1:0]        b_rd_addr,
   output issue_type                   issue,
   output logic                        c_clear,
   output logic [ADDR_BITS-1:0]        c_rd_addr,
   input  logic signed [SUM_BITS-1:0]  c_rd_data,
   input  logic                        mac_busy
);

   state_type                  state_ff;
   state_type                  state_in;
   logic [IDX_BITS-1:0]        c_ff, c_in;
   logic [IDX_BITS-1:0]        r_ff, r_in;
   logic [IDX_BITS-1:0]        j_ff, j_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                       rsp_status_ff, rsp_status_in;
   logic                       accept;
   logic                       in_range;
   logic                       read_hit;
   logic [SIZE_BITS-1:0]       n_m1;
   logic                       j_last, r_last, c_last;

   // Decode the request
   assign accept   = req_chan.valid && req_chan.ready;
   assign in_range = (SIZE_BITS'(req_chan.row) < eff_size) &&
                     (SIZE_BITS'(req_chan.col) < eff_size);
   assign read_hit = (req_chan.cmd == CMD_READ_C) && in_range;

   // Loop bounds
   assign n_m1   = eff_size - SIZE_BITS'(1);
   assign j_last = (SIZE_BITS'(j_ff) == n_m1);
   assign r_last = (SIZE_BITS'(r_ff) == n_m1);
   assign c_last = (SIZE_BITS'(c_ff) == n_m1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.cmd == CMD_MULTIPLY) begin
                  state_in = (eff_size == '0) ? ST_MAC_DRAIN : ST_MAC_RUN;
               end else if (read_hit) begin
                  state_in = ST_READ_WAIT;
               end
            end
         end
         ST_READ_WAIT: state_in = ST_IDLE;
         ST_MAC_RUN: begin
            if (j_last && r_last && c_last) begin
               state_in = ST_MAC_DRAIN;
            end
         end
         ST_MAC_DRAIN: begin
            if (!mac_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
      a_wr_en        = accept && (req_chan.cmd == CMD_WRITE_A) && in_range;
      b_wr_en        = accept && (req_chan.cmd == CMD_WRITE_B) && in_range;
      elem_wr_addr   = cell_addr(ADDR_BITS'(req_chan.row), ADDR_BITS'(req_chan.col));
      elem_wr_data   = ELEM_BITS'(req_chan.value);
      c_clear        = accept && (req_chan.cmd == CMD_MULTIPLY);
      c_rd_addr      = elem_wr_addr;
      a_rd_addr      = cell_addr(ADDR_BITS'(r_ff), ADDR_BITS'(j_ff));
      b_rd_addr      = cell_addr(ADDR_BITS'(j_ff), ADDR_BITS'(c_ff));
      issue.valid    = (state_ff == ST_MAC_RUN);
      issue.first    = (j_ff == '0);
      issue.last     = j_last;
      issue.c_addr   = cell_addr(ADDR_BITS'(r_ff), ADDR_BITS'(c_ff));
   end

   // Advance the loop counters: column outer, row middle, inner sum index
   always_comb begin
      c_in = c_ff;
      r_in = r_ff;
      j_in = j_ff;
      if (accept && (req_chan.cmd == CMD_MULTIPLY)) begin
         c_in = '0;
         r_in = '0;
         j_in = '0;
      end else if (state_ff == ST_MAC_RUN) begin
         if (j_last) begin
            j_in = '0;
            if (r_last) begin
               r_in = '0;
               c_in = c_ff + IDX_BITS'(1);
            end else begin
               r_in = r_ff + IDX_BITS'(1);
            end
         end else begin
            j_in = j_ff + IDX_BITS'(1);
         end
      end
   end

   // Load the response register, hold it while stalled
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (accept && (req_chan.cmd != CMD_MULTIPLY) && !read_hit) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_status_in = in_range ? STATUS_DONE : STATUS_RANGE;
      end else if (state_ff == ST_READ_WAIT) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = c_rd_data;
         rsp_status_in = STATUS_DONE;
      end else if ((state_ff == ST_MAC_DRAIN) && !mac_busy) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_status_in = STATUS_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         c_ff         <= '0;
         r_ff         <= '0;
         j_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         c_ff         <= c_in;
         r_ff         <= r_in;
         j_ff         <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.status     = rsp_status_ff;

`ifndef SYNTHESIS
   // The MAC pipeline is empty whenever new items can enter
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mac_busy)
      else $error("MAC pipeline busy while idle");

   // A good read enters the read wait for the product memory with the response slot free
   assert property (@(posedge clock) disable iff (reset)
      accept && read_hit |=> state_ff == ST_READ_WAIT && !rsp_valid_ff)
      else $error("read did not enter read wait with a free response slot");

   // The read wait always ends in a loaded response
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ_WAIT |=> rsp_valid_ff)
      else $error("read data not presented");

   // Writes and failed accesses answer in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      accept && (req_chan.cmd != CMD_MULTIPLY) && !read_hit |=> rsp_valid_ff)
      else $error("write or failed access gave no response");
`endif

endmodule

// ----- sv/dense_matrix_multiply_core.sv -----
// Top level of the dense matrix multiply core.
// Usage:
//   req_chan carries one command per item: write an element of A, write an
//   element of B, multiply (C = A * B over the size in use), or read an
//   element of C. rsp_chan returns exactly one item for each request, with
//   the read value (zero except for a good read of C) and a status (1 when
//   row or col is at or beyond the size in use; nothing is changed then).
//   csr_write_enable/csr_write_data set the size in use (clamped to 8);
//   write it only while the core is idle.
// Responses and rate:
//   Writes and failed accesses: response valid in the cycle after accept.
//   Reads of C: the registered product memory read, then the response
//   register. Multiply: one multiply-accumulate per cycle on the single
//   shared MAC, through its operand fetch, multiply, accumulate and
//   write back pipeline. The core works on one item at a time.
// Reset: clears the control state and all of C, size in use returns to 8;
//   A and B hold unknown data until written.
// Stalls: a result waits in the response register until rsp_chan.ready;
//   a new item is taken in the cycle that the waiting result leaves.
module dense_matrix_multiply_core import dmm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [SIZE_BITS-1:0] csr_write_data,
   dmm_req_if.sink              req_chan,
   dmm_rsp_if.source            rsp_chan
);

   logic [SIZE_BITS-1:0]        size_in_use_ff;
   logic [SIZE_BITS-1:0]        size_in_use_in;
   logic [SIZE_BITS-1:0]        eff_size;
   logic                        a_wr_en;
   logic                        b_wr_en;
   logic [ADDR_BITS-1:0]        elem_wr_addr;
   logic signed [ELEM_BITS-1:0] elem_wr_data;
   logic [ADDR_BITS-1:0]        a_rd_addr;
   logic [ADDR_BITS-1:0]        b_rd_addr;
   logic signed [ELEM_BITS-1:0] a_rd_data;
   logic signed [ELEM_BITS-1:0] b_rd_data;
   issue_type                   issue;
   cwrite_type                  c_wr;
   logic                        c_clear;
   logic [ADDR_BITS-1:0]        c_rd_addr;
   logic signed [SUM_BITS-1:0]  c_rd_data;
   logic                        mac_busy;

   // Size register
   assign size_in_use_in = csr_write_enable ? csr_write_data : size_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_in_use_ff <= SIZE_RESET;
      end else begin
         size_in_use_ff <= size_in_use_in;
      end
   end

   // Clamp the size to the matrix dimension
   assign eff_size = (size_in_use_ff > SIZE_BITS'(MAX_DIM)) ? SIZE_BITS'(MAX_DIM)
                                                            : size_in_use_ff;

   dmm_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .eff_size     (eff_size),
      .a_wr_en      (a_wr_en),
      .b_wr_en      (b_wr_en),
      .elem_wr_addr (elem_wr_addr),
      .elem_wr_data (elem_wr_data),
      .a_rd_addr    (a_rd_addr),
      .b_rd_addr    (b_rd_addr),
      .issue        (issue),
      .c_clear      (c_clear),
      .c_rd_addr    (c_rd_addr),
      .c_rd_data    (c_rd_data),
      .mac_busy     (mac_busy)
   );

   dmm_elem_ram u_left_ram (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (elem_wr_addr),
      .wr_data (elem_wr_data),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   dmm_elem_ram u_right_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (elem_wr_addr),
      .wr_data (elem_wr_data),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   dmm_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .issue  (issue),
      .a_data (a_rd_data),
      .b_data (b_rd_data),
      .c_wr   (c_wr),
      .busy   (mac_busy)
   );

   dmm_product_mem u_product_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (c_clear),
      .wr      (c_wr),
      .rd_addr (c_rd_addr),
      .rd_data (c_rd_data)
   );

endmodule
